### rtl/assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DTN_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define DTN_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define DTN_ASSERT_ALWAYS(lbl, expr)
`define DTN_ASSERT_IMPL(lbl, ante, cons)
`endif
`endif

### rtl/dtn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package dtn_pkg;

    localparam int DEPTH_BITS = 24;
    localparam int COL_BITS   = 11;
    localparam int DIM_BITS   = 12;
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;
    localparam int MAG_BITS   = 25;
    localparam int SQ_BITS    = 50;
    localparam int D_BITS     = 51;
    localparam int CMP_BITS   = 66;
    localparam int Q_BITS     = 7;
    localparam int STEP_BITS  = 3;

    localparam logic [DIM_BITS-1:0] DIM_MIN      = 12'd3;
    localparam logic [DIM_BITS-1:0] WIDTH_LIMIT  = DIM_BITS'(MAX_WIDTH);
    localparam logic [DIM_BITS-1:0] HEIGHT_LIMIT = DIM_BITS'(MAX_HEIGHT);
    localparam logic [DIM_BITS-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_BITS-1:0] HEIGHT_RESET = 12'd480;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [D_BITS-1:0]   S_SQ      = D_BITS'(1) << 18;
    localparam logic [13:0]         RATIO_SQ  = 14'd16129;
    localparam logic [CMP_BITS-1:0] RHS_BLUE  = CMP_BITS'(16129) << 18;
    localparam logic [31:0]         NO_SURFACE_ARGB = 32'hff8080ff;
    localparam logic [7:0]          ALPHA     = 8'hff;
    localparam logic [7:0]          MID_LEVEL = 8'd128;

    typedef struct packed {
        logic signed [DEPTH_BITS-1:0] depth;
        logic                         depth_absent;
        logic                         start_of_frame;
    } pixel_t;

    typedef struct packed {
        logic [COL_BITS-1:0] column;
        logic [COL_BITS-1:0] row;
        logic [31:0]         argb;
        logic                last_of_frame;
    } result_t;

    typedef struct packed {
        logic                         absent;
        logic signed [DEPTH_BITS-1:0] depth;
    } entry_t;

    typedef struct packed {
        entry_t              lft;
        entry_t              ctr;
        entry_t              rgt;
        entry_t              top;
        entry_t              bot;
        logic [COL_BITS-1:0] column;
        logic [COL_BITS-1:0] row;
        logic                last;
    } work_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SLOPE,
        B_SQUARE,
        B_SUM,
        B_ITER,
        B_DONE
    } back_state_t;

endpackage
`default_nettype wire

### rtl/dtn_front.sv
`timescale 1ns / 1ps
`default_nettype none
module dtn_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [dtn_pkg::DIM_BITS-1:0]  cfg_data,
    input  wire logic                          pixel_valid,
    output logic                               pixel_ready,
    input  wire dtn_pkg::pixel_t               pixel,
    output logic                               push,
    output dtn_pkg::work_t                     push_data,
    input  wire dtn_pkg::q_stat_t              q_stat
);

    logic [dtn_pkg::DIM_BITS-1:0] width_reg, height_reg;
    logic [dtn_pkg::DIM_BITS-1:0] w, h;
    logic [dtn_pkg::COL_BITS-1:0] col_reg, row_reg, col_next, row_next;
    logic [dtn_pkg::COL_BITS-1:0] col_cur, row_cur;
    logic                         a_valid_reg;
    dtn_pkg::entry_t              a_cur_reg, cur;
    logic [dtn_pkg::COL_BITS-1:0] a_col_reg, a_row_reg;
    logic                         a_emit_reg, a_last_reg, emit, last;
    dtn_pkg::entry_t              rd_one_reg, rd_two_reg;
    dtn_pkg::entry_t              win0_reg, win2_reg, win3_reg, win4_reg;
    dtn_pkg::entry_t              line_one_mem [dtn_pkg::MAX_WIDTH];
    dtn_pkg::entry_t              line_two_mem [dtn_pkg::MAX_WIDTH];
    logic                         accept, b_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= dtn_pkg::WIDTH_RESET;
            height_reg <= dtn_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == dtn_pkg::REG_IMAGE_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    always_comb
    begin
        w = width_reg;
        if (width_reg < dtn_pkg::DIM_MIN)
            w = dtn_pkg::DIM_MIN;
        else if (width_reg > dtn_pkg::WIDTH_LIMIT)
            w = dtn_pkg::WIDTH_LIMIT;
        h = height_reg;
        if (height_reg < dtn_pkg::DIM_MIN)
            h = dtn_pkg::DIM_MIN;
        else if (height_reg > dtn_pkg::HEIGHT_LIMIT)
            h = dtn_pkg::HEIGHT_LIMIT;
    end

    assign b_fire      = a_valid_reg && (!a_emit_reg || !q_stat.full);
    assign pixel_ready = !a_valid_reg || b_fire;
    assign accept      = pixel_valid && pixel_ready;
    assign push        = b_fire && a_emit_reg;

    always_comb
    begin
        cur.absent = pixel.depth_absent;
        cur.depth  = pixel.depth;
        col_cur = pixel.start_of_frame ? '0 : col_reg;
        row_cur = pixel.start_of_frame ? '0 : row_reg;
        emit = ({1'b0, col_cur} < w) && ({1'b0, row_cur} < h)
            && (col_cur >= 11'd2) && (row_cur >= 11'd2);
        last = ({1'b0, col_cur} == w - 12'd1) && ({1'b0, row_cur} == h - 12'd1);
        if ({1'b0, col_cur} + 12'd1 >= w)
        begin
            col_next = '0;
            row_next = ({1'b0, row_cur} + 12'd1 >= h) ? '0 : row_cur + 11'd1;
        end
        else
        begin
            col_next = col_cur + 11'd1;
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (accept)
                a_valid_reg <= 1'b1;
            else if (b_fire)
                a_valid_reg <= 1'b0;
        end
    end

    // forward the line write when the same column is read on that edge
    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            line_two_mem[a_col_reg] <= rd_one_reg;
            line_one_mem[a_col_reg] <= a_cur_reg;
            win0_reg <= rd_two_reg;
            win3_reg <= win2_reg;
            win2_reg <= rd_one_reg;
            win4_reg <= a_cur_reg;
        end
        if (accept)
        begin
            a_cur_reg  <= cur;
            a_col_reg  <= col_cur;
            a_row_reg  <= row_cur;
            a_emit_reg <= emit;
            a_last_reg <= last;
            if (b_fire && a_col_reg == col_cur)
            begin
                rd_one_reg <= a_cur_reg;
                rd_two_reg <= rd_one_reg;
            end
            else
            begin
                rd_one_reg <= line_one_mem[col_cur];
                rd_two_reg <= line_two_mem[col_cur];
            end
        end
    end

    always_comb
    begin
        push_data.lft    = win3_reg;
        push_data.ctr    = win2_reg;
        push_data.rgt    = rd_one_reg;
        push_data.top    = win0_reg;
        push_data.bot    = win4_reg;
        push_data.column = a_col_reg - 11'd1;
        push_data.row    = a_row_reg - 11'd1;
        push_data.last   = a_last_reg;
    end

endmodule
`default_nettype wire

### rtl/dtn_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module dtn_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire dtn_pkg::work_t   push_data,
    input  wire logic             pop,
    output dtn_pkg::work_t        pop_data,
    output dtn_pkg::q_stat_t      q_stat
);

    dtn_pkg::work_t slot_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;

    assign q_stat.valid = (count_reg != 2'd0);
    assign q_stat.full  = (count_reg == 2'd2);
    assign pop_data     = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule
`default_nettype wire

### rtl/dtn_back.sv
`timescale 1ns / 1ps
`default_nettype none
module dtn_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dtn_pkg::q_stat_t q_stat,
    output logic                  pop,
    input  wire dtn_pkg::work_t   work,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output dtn_pkg::result_t      result
);

    localparam logic [dtn_pkg::STEP_BITS-1:0] STEP_TOP =
        dtn_pkg::STEP_BITS'(dtn_pkg::Q_BITS - 1);

    dtn_pkg::back_state_t state_reg, state_next;
    dtn_pkg::work_t       work_reg;
    logic                 xneg_reg, yneg_reg;
    logic [dtn_pkg::MAG_BITS-1:0] mx_reg, my_reg, mx, my;
    logic [dtn_pkg::SQ_BITS-1:0]  x2_reg, y2_reg;
    logic [dtn_pkg::D_BITS-1:0]   d_reg;
    logic [dtn_pkg::CMP_BITS-1:0] rhs_reg [3];
    logic [dtn_pkg::CMP_BITS-1:0] dq_reg  [3];
    logic [dtn_pkg::CMP_BITS-1:0] dq2_reg [3];
    logic [dtn_pkg::CMP_BITS-1:0] cand    [3];
    logic [dtn_pkg::Q_BITS-1:0]   q_reg   [3];
    logic [dtn_pkg::STEP_BITS-1:0] step_reg;
    logic signed [25:0] dc, dl, dr, dt, db, x, y;
    logic               result_valid_reg, load_out;
    dtn_pkg::result_t   result_reg;
    logic [7:0]         red, green, blue;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dtn_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            dtn_pkg::B_IDLE:
            begin
                if (q_stat.valid)
                begin
                    pop        = 1'b1;
                    state_next = dtn_pkg::B_SLOPE;
                end
            end
            dtn_pkg::B_SLOPE:  state_next = dtn_pkg::B_SQUARE;
            dtn_pkg::B_SQUARE: state_next = dtn_pkg::B_SUM;
            dtn_pkg::B_SUM:    state_next = dtn_pkg::B_ITER;
            dtn_pkg::B_ITER:
            begin
                if (step_reg == '0)
                    state_next = dtn_pkg::B_DONE;
            end
            dtn_pkg::B_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    load_out   = 1'b1;
                    state_next = dtn_pkg::B_IDLE;
                end
            end
            default: state_next = dtn_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        dc = 26'(work_reg.ctr.depth);
        dl = 26'(work_reg.lft.depth);
        dr = 26'(work_reg.rgt.depth);
        dt = 26'(work_reg.top.depth);
        db = 26'(work_reg.bot.depth);
        if (work_reg.top.absent == work_reg.bot.absent)
            y = work_reg.top.absent ? '0 : db - dt;
        else
            y = work_reg.top.absent ? (db - dc) <<< 1 : (dc - dt) <<< 1;
        if (!work_reg.lft.absent && !work_reg.rgt.absent)
            x = dr - dl;
        else if (!work_reg.lft.absent)
            x = (dc - dl) <<< 1;
        else if (!work_reg.rgt.absent)
            x = (dr - dc) <<< 1;
        else
            x = '0;
        mx = x[25] ? 25'(-x) : 25'(x);
        my = y[25] ? 25'(-y) : 25'(y);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            cand[i] = dq2_reg[i] + (dq_reg[i] << (step_reg + 3'd1))
                + (dtn_pkg::CMP_BITS'(d_reg) << {step_reg, 1'b0});
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            work_reg <= work;
        if (state_reg == dtn_pkg::B_SLOPE)
        begin
            xneg_reg <= x[25];
            yneg_reg <= y[25];
            mx_reg   <= mx;
            my_reg   <= my;
        end
        if (state_reg == dtn_pkg::B_SQUARE)
        begin
            x2_reg <= mx_reg * mx_reg;
            y2_reg <= my_reg * my_reg;
        end
        if (state_reg == dtn_pkg::B_SUM)
        begin
            d_reg <= dtn_pkg::S_SQ + dtn_pkg::D_BITS'(x2_reg) + dtn_pkg::D_BITS'(y2_reg);
            rhs_reg[0] <= dtn_pkg::CMP_BITS'(x2_reg) * dtn_pkg::CMP_BITS'(dtn_pkg::RATIO_SQ);
            rhs_reg[1] <= dtn_pkg::CMP_BITS'(y2_reg) * dtn_pkg::CMP_BITS'(dtn_pkg::RATIO_SQ);
            rhs_reg[2] <= dtn_pkg::RHS_BLUE;
            step_reg   <= STEP_TOP;
            for (int i = 0; i < 3; i++)
            begin
                q_reg[i]   <= '0;
                dq_reg[i]  <= '0;
                dq2_reg[i] <= '0;
            end
        end
        if (state_reg == dtn_pkg::B_ITER)
        begin
            step_reg <= step_reg - 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                if (cand[i] <= rhs_reg[i])
                begin
                    q_reg[i][step_reg] <= 1'b1;
                    dq2_reg[i]         <= cand[i];
                    dq_reg[i]          <= dq_reg[i]
                        + (dtn_pkg::CMP_BITS'(d_reg) << step_reg);
                end
            end
        end
        if (load_out)
            result_reg <= '{column: work_reg.column, row: work_reg.row,
                            argb: work_reg.ctr.absent ? dtn_pkg::NO_SURFACE_ARGB
                                : {dtn_pkg::ALPHA, red, green, blue},
                            last_of_frame: work_reg.last};
    end

    always_comb
    begin
        red   = xneg_reg ? dtn_pkg::MID_LEVEL - 8'(q_reg[0])
                         : dtn_pkg::MID_LEVEL + 8'(q_reg[0]);
        green = yneg_reg ? dtn_pkg::MID_LEVEL - 8'(q_reg[1])
                         : dtn_pkg::MID_LEVEL + 8'(q_reg[1]);
        blue  = dtn_pkg::MID_LEVEL + 8'(q_reg[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (load_out)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
`default_nettype wire

### rtl/depth_to_normal_map.sv
// Throughput: one pixel per cycle while the queue is not full; each interior
// result passes the normalizing unit's slope, square, sum, iteration and done
// states in that order, one quotient bit per iteration step.
// A two-entry queue lets the pixel front run on while the unit works.
// Reset: counters to zero, size to 640 by 480; line stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module depth_to_normal_map (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [dtn_pkg::DIM_BITS-1:0]  cfg_data,
    input  wire logic                          pixel_valid,
    output logic                               pixel_ready,
    input  wire dtn_pkg::pixel_t               pixel,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output dtn_pkg::result_t                   result
);

    logic             push, pop;
    dtn_pkg::work_t   push_data, pop_data;
    dtn_pkg::q_stat_t q_stat;

    dtn_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .push        (push),
        .push_data   (push_data),
        .q_stat      (q_stat)
    );

    dtn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    dtn_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_stat       (q_stat),
        .pop          (pop),
        .work         (pop_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    `DTN_ASSERT_IMPL(a_no_push_when_full, push, !q_stat.full)
    `DTN_ASSERT_IMPL(a_pop_only_valid, pop, q_stat.valid)
    `DTN_ASSERT_IMPL(a_alpha_opaque, result_valid, result.argb[31:24] == 8'hff)

endmodule
`default_nettype wire

### tb/sv/tb_depth_to_normal_map.sv
`timescale 1ns / 1ps
module tb_depth_to_normal_map;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_index = dtn_pkg::REG_IMAGE_WIDTH;
    logic [dtn_pkg::DIM_BITS-1:0] cfg_data = '0;
    logic pixel_valid = 1'b0;
    logic pixel_ready;
    dtn_pkg::pixel_t pixel = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    dtn_pkg::result_t result;

    depth_to_normal_map i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .pixel_valid(pixel_valid),
        .pixel_ready(pixel_ready),
        .pixel(pixel),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result(result)
    );

    always #1 clk = ~clk;

    dtn_pkg::pixel_t pending_pixels[$];
    dtn_pkg::result_t expected_normals[$];
    dtn_pkg::entry_t row_above[dtn_pkg::MAX_WIDTH];
    dtn_pkg::entry_t row_two_above[dtn_pkg::MAX_WIDTH];
    dtn_pkg::entry_t win[6];
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    logic [dtn_pkg::DIM_BITS-1:0] width_reg = dtn_pkg::WIDTH_RESET;
    logic [dtn_pkg::DIM_BITS-1:0] height_reg = dtn_pkg::HEIGHT_RESET;
    int errors = 0;
    int pixels_sent = 0;
    int normals_seen = 0;
    int settings_used = 0;
    int cycles = 0;
    bit quiet = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    function automatic int unsigned clamp_dim(input logic [dtn_pkg::DIM_BITS-1:0] v,
                                              input int hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic logic [6:0] scaled_ratio(input logic [71:0] mag, input logic [71:0] d);
        logic [71:0] rhs;
        logic [71:0] t;
        logic [6:0] q;
        rhs = mag * mag * 72'd16129;
        q = '0;
        for (int b = 6; b >= 0; b--)
        begin
            t = {65'd0, q | 7'(1 << b)};
            if (d * t * t <= rhs)
                q = t[6:0];
        end
        return q;
    endfunction

    function automatic logic [7:0] slope_level(input longint v, input logic [71:0] d);
        logic [6:0] q;
        q = scaled_ratio(v < 0 ? 72'(-v) : 72'(v), d);
        return v < 0 ? 8'd128 - q : 8'd128 + q;
    endfunction

    function automatic logic [31:0] normal_color(input dtn_pkg::entry_t lft,
                                                 input dtn_pkg::entry_t ctr,
                                                 input dtn_pkg::entry_t rgt,
                                                 input dtn_pkg::entry_t top,
                                                 input dtn_pkg::entry_t bot);
        longint c;
        longint x;
        longint y;
        logic [71:0] d;
        if (ctr.absent)
            return dtn_pkg::NO_SURFACE_ARGB;
        c = ctr.depth;
        if (top.absent == bot.absent)
            y = top.absent ? 0 : longint'(bot.depth) - longint'(top.depth);
        else
            y = top.absent ? 2 * (longint'(bot.depth) - c) : 2 * (c - longint'(top.depth));
        if (!lft.absent && !rgt.absent)
            x = longint'(rgt.depth) - longint'(lft.depth);
        else if (!lft.absent)
            x = 2 * (c - longint'(lft.depth));
        else if (!rgt.absent)
            x = 2 * (longint'(rgt.depth) - c);
        else
            x = 0;
        d = (72'd1 << 18) + 72'(x * x) + 72'(y * y);
        return {8'hff, slope_level(x, d), slope_level(y, d),
                8'd128 + {1'b0, scaled_ratio(72'd512, d)}};
    endfunction

    task automatic predict_normal(input dtn_pkg::pixel_t p);
        int unsigned w;
        int unsigned h;
        dtn_pkg::entry_t cur;
        dtn_pkg::entry_t top_new;
        dtn_pkg::entry_t mid_new;
        dtn_pkg::result_t r;
        w = clamp_dim(width_reg, dtn_pkg::MAX_WIDTH);
        h = clamp_dim(height_reg, dtn_pkg::MAX_HEIGHT);
        cur.absent = p.depth_absent;
        cur.depth = p.depth;
        if (p.start_of_frame)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        top_new = row_two_above[col_pos];
        mid_new = row_above[col_pos];
        if (col_pos < w && row_pos < h && col_pos >= 2 && row_pos >= 2)
        begin
            r.column = dtn_pkg::COL_BITS'(col_pos - 1);
            r.row = dtn_pkg::COL_BITS'(row_pos - 1);
            r.argb = normal_color(win[3], win[2], mid_new, win[0], win[4]);
            r.last_of_frame = (col_pos == w - 1 && row_pos == h - 1);
            expected_normals.push_back(r);
        end
        row_two_above[col_pos] = mid_new;
        row_above[col_pos] = cur;
        win[1] = win[0];
        win[0] = top_new;
        win[3] = win[2];
        win[2] = mid_new;
        win[5] = win[4];
        win[4] = cur;
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && pixel_ready)
            begin
                predict_normal(pixel);
                pixels_sent++;
            end
            if (!pixel_valid || pixel_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    pixel_valid <= 1'b0;
                end
                else if (pending_pixels.size() == 0)
                    pixel_valid <= 1'b0;
                else if (!quiet && $urandom_range(0, 19) == 0)
                begin
                    send_gap = $urandom_range(0, 11);
                    pixel_valid <= 1'b0;
                end
                else
                begin
                    pixel <= pending_pixels.pop_front();
                    pixel_valid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                normals_seen++;
                if (expected_normals.size() == 0)
                begin
                    $error("unexpected result beat: column %0d row %0d", result.column, result.row);
                    errors++;
                end
                else
                begin
                    dtn_pkg::result_t e;
                    e = expected_normals.pop_front();
                    if (result.column !== e.column)
                    begin
                        $error("column expected %0d got %0d", e.column, result.column);
                        errors++;
                    end
                    if (result.row !== e.row)
                    begin
                        $error("row expected %0d got %0d", e.row, result.row);
                        errors++;
                    end
                    if (result.argb !== e.argb)
                    begin
                        $error("argb expected %h got %h", e.argb, result.argb);
                        errors++;
                    end
                    if (result.last_of_frame !== e.last_of_frame)
                    begin
                        $error("last_of_frame expected %0d got %0d", e.last_of_frame,
                               result.last_of_frame);
                        errors++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 19) == 0)
            begin
                recv_gap = $urandom_range(0, 11);
                result_ready <= 1'b0;
            end
            else
                result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic wait_idle();
        while (pending_pixels.size() != 0 || pixel_valid || expected_normals.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_size(input logic [dtn_pkg::DIM_BITS-1:0] w,
                            input logic [dtn_pkg::DIM_BITS-1:0] h);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= dtn_pkg::REG_IMAGE_WIDTH;
        cfg_data <= w;
        width_reg = w;
        @(posedge clk);
        cfg_index <= dtn_pkg::REG_IMAGE_HEIGHT;
        cfg_data <= h;
        height_reg = h;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic dtn_pkg::pixel_t rand_pixel(input bit sof, input int base);
        dtn_pkg::pixel_t p;
        case ($urandom_range(0, 7))
            0: p.depth = dtn_pkg::DEPTH_BITS'($urandom);
            1: p.depth = $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
            2: p.depth = dtn_pkg::DEPTH_BITS'(base + $urandom_range(0, 65535) - 32768);
            default: p.depth = dtn_pkg::DEPTH_BITS'(base + $urandom_range(0, 1023) - 512);
        endcase
        p.depth_absent = ($urandom_range(0, 6) == 0);
        p.start_of_frame = sof;
        return p;
    endfunction

    task automatic add_frame(input int w, input int h, input bit broken);
        int n;
        int base;
        bit sof;
        n = broken ? $urandom_range(1, w * h - 1) : w * h;
        base = $urandom_range(0, 1 << 23) - (1 << 22);
        sof = ($urandom_range(0, 4) != 0);
        for (int i = 0; i < n; i++)
            pending_pixels.push_back(rand_pixel(i == 0 && sof, base));
    endtask

    task automatic run_frames(input int w, input int h, input int frames);
        add_frame(w, h, 1'b0);
        pending_pixels[pending_pixels.size() - w * h].start_of_frame = 1'b1;
        for (int f = 1; f < frames; f++)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                add_frame(w, h, 1'b1);
                add_frame(w, h, 1'b0);
                pending_pixels[pending_pixels.size() - w * h].start_of_frame = 1'b1;
            end
            else
                add_frame(w, h, 1'b0);
        end
    endtask

    initial
    begin
        dtn_pkg::pixel_t p;
        int w;
        int h;
        int total;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_size(12'd5, 12'd4);
        for (int i = 0; i < 20; i++)
        begin
            p.start_of_frame = (i == 0);
            case (i % 4)
                0: p.depth = 24'h7fffff;
                1: p.depth = 24'h800000;
                2: p.depth = 24'h000000;
                default: p.depth = 24'h000100;
            endcase
            p.depth_absent = (i == 1 || i == 2 || i == 6 || i == 9 || i == 10 ||
                              i == 11 || i == 13 || i == 14 || i == 18);
            pending_pixels.push_back(p);
        end
        set_size(12'd3, 12'd3);
        for (int i = 0; i < 9; i++)
        begin
            p.start_of_frame = (i == 0);
            p.depth = (i == 4) ? 24'h800000 : 24'h7fffff;
            p.depth_absent = (i == 3 || i == 5);
            pending_pixels.push_back(p);
        end

        set_size(12'd0, 12'd2);
        run_frames(3, 3, 4);

        total = 0;
        while (total < 1260)
        begin
            w = $urandom_range(3, 14);
            h = $urandom_range(3, 8);
            if (total > 1030)
                quiet = 1'b1;
            set_size(12'(w), 12'(h));
            run_frames(w, h, $urandom_range(2, 5));
            total += pending_pixels.size();
        end

        wait_idle();
        $display("Covered %0d pixels, %0d normals over %0d size settings.",
                 pixels_sent, normals_seen, settings_used);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
